>>> src/rrip_pkg.sv
// ----------------------------------------------------------------------------
// rrip_pkg
// Shared constants and the signature hash for the RRIP replacement unit.
// ----------------------------------------------------------------------------
`default_nettype none
package rrip_pkg;
	localparam int SETS        = 2048;
	localparam int WAYS        = 16;
	localparam int LEADER_SETS = 64;
	localparam int SIG_BITS    = 6;
	localparam int PSEL_BITS   = 10;
	localparam int SET_W       = $clog2(SETS);
	localparam int WAY_W       = $clog2(WAYS);
	localparam int SIG_N       = 1 << SIG_BITS;
	localparam int SETROW_W    = 2 * WAYS;
	localparam int SIGROW_W    = 2 * SIG_N;
	localparam int STRM_W      = 2 + 64 + 32;
	localparam logic [PSEL_BITS-1:0] PSEL_TOP  = {PSEL_BITS{1'b1}};
	localparam logic [PSEL_BITS-1:0] PSEL_HALF = PSEL_TOP >> 1;

	localparam logic [1:0] REG_DECAY  = 2'd0;
	localparam logic [1:0] REG_BIP    = 2'd1;
	localparam logic [1:0] REG_STRIDE = 2'd2;

	localparam logic FUNC_VICTIM = 1'b0;

	// Signature hash of the program counter.
	function automatic logic [SIG_BITS-1:0] sig_hash(input logic [63:0] pc);
		logic [63:0] h;
		h = pc ^ (pc >> 9) ^ (pc >> 15);
		return h[SIG_BITS-1:0];
	endfunction
endpackage
`default_nettype wire

>>> src/rrip_ram.sv
// ----------------------------------------------------------------------------
// rrip_ram
// Generic single-port-write, single-read RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module rrip_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> src/rrip_ship_dip_cache_replacement_unit.sv
// ----------------------------------------------------------------------------
// rrip_ship_dip_cache_replacement_unit
// Cache replacement engine: RRPV victim choice with streaming, signature,
// dead-block and set-dueling insertion.
// ----------------------------------------------------------------------------
// Channel   Direction  Beat marked by
// command   in         start & !busy
// result    out        done (one cycle, no back-pressure)
// config    in         cfg_valid & cfg_ready
//
// An item takes two steps: a set-row read of the metadata memories, then
// the modify and write-back, which also registers the result strobe.
// After reset a clearing pass over all SETS (2048) sets initialises the
// memories; busy is high meanwhile. A dead-counter decay runs a like sweep,
// one set per cycle, after the update that triggers it, halving the counters.
// The receiver cannot stall; busy is high in clearing, sweep and write-back.
// ----------------------------------------------------------------------------
`default_nettype none
module rrip_ship_dip_cache_replacement_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        func,
	input  wire logic [10:0] set_index,
	input  wire logic [3:0]  way,
	input  wire logic [63:0] address,
	input  wire logic [63:0] pc,
	input  wire logic        hit,
	output logic             done,
	output logic [3:0]       victim_way,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	localparam int SW = rrip_pkg::SET_W;
	localparam int WW = rrip_pkg::WAY_W;
	localparam int RW = rrip_pkg::SETROW_W;
	localparam int PW = rrip_pkg::PSEL_BITS;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_WORK  = 2'd2;
	localparam logic [1:0] ST_DECAY = 2'd3;

	logic [1:0]    state_q;
	logic [SW:0]   sweep_q;
	logic [31:0]   decay_q;
	logic [15:0]   bipp_q;
	logic [20:0]   win_q;
	logic [31:0]   upd_q;
	logic [15:0]   bim_q;
	logic [rrip_pkg::PSEL_BITS-1:0] psel_q;

	logic          func_s1, hit_s1;
	logic [SW-1:0] set_s1;
	logic [WW-1:0] way_s1;
	logic [63:0]   addr_s1;
	logic [rrip_pkg::SIG_BITS-1:0] sig_s1;
	logic          accept;
	logic          sweep_now;
	logic [SW-1:0] sweep_set;

	// RAM ports.
	logic          we;
	logic [SW-1:0] waddr, raddr;
	logic [RW-1:0] rr_w, rr_r, dc_w, dc_r;
	logic [rrip_pkg::SIGROW_W-1:0] sg_w, sg_r;
	logic [rrip_pkg::STRM_W-1:0]   st_w, st_r;

	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign sweep_set = sweep_q[SW-1:0];
	assign sweep_now = (state_q == ST_CLEAR) || (state_q == ST_DECAY);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q <= 32'd100000;
			bipp_q  <= 16'd32;
			win_q   <= 21'd8192;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rrip_pkg::REG_DECAY:  decay_q <= cfg_data;
				rrip_pkg::REG_BIP:    bipp_q  <= cfg_data[15:0];
				rrip_pkg::REG_STRIDE: win_q   <= cfg_data[20:0];
				default: ;
			endcase
		end
	end

	// Capture of the accepted command.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= func;
			hit_s1  <= hit;
			set_s1  <= set_index[SW-1:0];
			way_s1  <= way[WW-1:0];
			addr_s1 <= address;
			sig_s1  <= rrip_pkg::sig_hash(pc);
		end
	end

	// In a decay sweep the next row is read while the current row is written.
	assign raddr = accept ? set_index[SW-1:0]
		: (state_q == ST_DECAY ? sweep_set + SW'(1) : sweep_set);

	rrip_ram #(.WIDTH(RW), .DEPTH(rrip_pkg::SETS)) u_rrpv (
		.clk(clk), .we(we), .waddr(waddr), .wdata(rr_w), .raddr(raddr), .rdata(rr_r));
	rrip_ram #(.WIDTH(RW), .DEPTH(rrip_pkg::SETS)) u_dead (
		.clk(clk), .we(we), .waddr(waddr), .wdata(dc_w), .raddr(raddr), .rdata(dc_r));
	rrip_ram #(.WIDTH(rrip_pkg::SIGROW_W), .DEPTH(rrip_pkg::SETS)) u_sig (
		.clk(clk), .we(we), .waddr(waddr), .wdata(sg_w), .raddr(raddr), .rdata(sg_r));
	rrip_ram #(.WIDTH(rrip_pkg::STRM_W), .DEPTH(rrip_pkg::SETS)) u_strm (
		.clk(clk), .we(we), .waddr(waddr), .wdata(st_w), .raddr(raddr), .rdata(st_r));

	// Update datapath and victim search.
	logic [1:0]  conf, conf_n, dnew;
	logic [63:0] paddr;
	logic [31:0] diff;
	logic [31:0] pstr, stride, mag;
	logic [1:0]  sgc, sgc_n;
	logic        lead_s, lead_b, use_s, decay_fire, bim_fire;
	logic [31:0] upd_n;
	logic [15:0] bim_n;
	logic [1:0]  ins;
	logic [RW-1:0] dc_upd, dc_half, rr_upd;
	logic [rrip_pkg::SIGROW_W-1:0] sg_upd;
	logic [WW-1:0] vic;
	logic          found;

	always_comb begin
		conf  = st_r[97:96];
		paddr = st_r[95:32];
		pstr  = st_r[31:0];
		diff  = addr_s1[31:0] - paddr[31:0];
		stride = (paddr != 64'd0) ? diff : 32'd0;
		mag   = stride[31] ? (32'd0 - stride) : stride;
		conf_n = (conf != 2'd0) ? conf - 2'd1 : 2'd0;
		if (stride != 32'd0 && mag < {11'd0, win_q}) begin
			if (stride == pstr) begin
				conf_n = (conf != 2'd3) ? conf + 2'd1 : 2'd3;
			end
		end else begin
			stride = 32'd0;
		end
		st_w = sweep_now ? {2'd0, 64'd0, 32'd0}
			: {conf_n, addr_s1, (stride != 32'd0 && mag < {11'd0, win_q}) ? stride : 32'd0};
		if (state_q == ST_DECAY) st_w = st_r;

		sgc   = sg_r[2*sig_s1 +: 2];
		sgc_n = (hit_s1 && sgc != 2'd3) ? sgc + 2'd1 : sgc;
		sg_upd = sg_r;
		sg_upd[2*sig_s1 +: 2] = sgc_n;

		dnew = dc_r[2*way_s1 +: 2];
		if (hit_s1) dnew = 2'd0;
		else if (dnew != 2'd3) dnew = dnew + 2'd1;
		dc_upd = dc_r;
		dc_upd[2*way_s1 +: 2] = dnew;

		upd_n = upd_q + 32'd1;
		decay_fire = (upd_n >= decay_q);
		for (int i = 0; i < rrip_pkg::WAYS; i++) begin
			dc_half[2*i +: 2] = {1'b0, dc_upd[2*i+1]};
		end

		lead_s = set_s1 < SW'(rrip_pkg::LEADER_SETS);
		lead_b = set_s1 >= SW'(rrip_pkg::SETS - rrip_pkg::LEADER_SETS);
		use_s  = lead_s ? 1'b1 : (lead_b ? 1'b0 : (psel_q < rrip_pkg::PSEL_HALF));
		ins = 2'd3;
		if (conf_n < 2'd2) begin
			if (sgc_n >= 2'd2) ins = 2'd2;
			if ((decay_fire ? {1'b0, dnew[1]} : dnew) >= 2'd2) ins = 2'd3;
		end
		bim_n = bim_q + 16'd1;
		bim_fire = (bim_n >= bipp_q);
		if (!use_s) ins = bim_fire ? 2'd2 : 2'd3;
		rr_upd = rr_r;
		rr_upd[2*way_s1 +: 2] = hit_s1 ? 2'd0 : ins;

		// Victim: first RRPV 3, then highest lower RRPV with dead counter >= 2.
		vic = '0;
		found = 1'b0;
		for (int i = 0; i < rrip_pkg::WAYS; i++) begin
			if (!found && rr_r[2*i +: 2] == 2'd3) begin
				vic = WW'(i); found = 1'b1;
			end
		end
		for (int r = 2; r >= 0; r--) begin
			for (int i = 0; i < rrip_pkg::WAYS; i++) begin
				if (!found && rr_r[2*i +: 2] == 2'(r) && dc_r[2*i+1]) begin
					vic = WW'(i); found = 1'b1;
				end
			end
		end
	end

	// Write-back select. The sweep leaves the updated set alone, since its
	// row was already halved at write-back.
	always_comb begin
		we = 1'b0;
		waddr = set_s1;
		rr_w = rr_upd;
		dc_w = decay_fire ? dc_half : dc_upd;
		sg_w = sg_upd;
		unique case (state_q)
			ST_CLEAR: begin
				we = 1'b1; waddr = sweep_set;
				rr_w = {RW{1'b1}}; dc_w = '0;
				for (int i = 0; i < rrip_pkg::SIG_N; i++) sg_w[2*i +: 2] = 2'd1;
			end
			ST_DECAY: begin
				we = (sweep_set != set_s1); waddr = sweep_set; rr_w = rr_r; sg_w = sg_r;
				for (int i = 0; i < rrip_pkg::WAYS; i++) dc_w[2*i +: 2] = {1'b0, dc_r[2*i+1]};
			end
			ST_WORK: we = (func_s1 != rrip_pkg::FUNC_VICTIM);
			default: ;
		endcase
	end

	// Control sequencer and global counters. The decay sweep skips the
	// updated set, which is already halved at write-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			sweep_q <= '0;
			upd_q   <= '0;
			bim_q   <= '0;
			psel_q  <= rrip_pkg::PSEL_HALF;
			done    <= 1'b0;
			victim_way <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					sweep_q <= sweep_q + (SW+1)'(1);
					if (sweep_q == (SW+1)'(rrip_pkg::SETS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: if (accept) state_q <= ST_WORK;
				ST_WORK: begin
					done <= 1'b1;
					victim_way <= (func_s1 == rrip_pkg::FUNC_VICTIM) ? 4'(vic) : 4'd0;
					state_q <= ST_IDLE;
					if (func_s1 != rrip_pkg::FUNC_VICTIM) begin
						if (lead_s && !hit_s1 && psel_q != rrip_pkg::PSEL_TOP)
							psel_q <= psel_q + PW'(1);
						if (lead_b && hit_s1 && psel_q != '0)
							psel_q <= psel_q - PW'(1);
						upd_q <= decay_fire ? 32'd0 : upd_n;
						if (!hit_s1 && !use_s) bim_q <= bim_fire ? 16'd0 : bim_n;
						if (decay_fire) begin
							state_q <= ST_DECAY;
							sweep_q <= '0;
						end
					end
				end
				ST_DECAY: begin
					sweep_q <= sweep_q + (SW+1)'(1);
					if (sweep_q == (SW+1)'(rrip_pkg::SETS - 1)) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The sweep reads row k+1 while it writes row k, so row 0 is read in the
	// write-back cycle, when raddr falls back to the sweep address 0.
	// The updated set is not rewritten by the sweep.

	// Assertions.
	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WORK) |=> done) else $error("missing result strobe");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WORK) |-> !accept) else $error("accept while working");
	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("strobe longer than one cycle");
endmodule
`default_nettype wire

>>> bench/rrip_replacement_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrip_replacement_checker
// Watches the command, result and configuration channels of the replacement
// unit. It keeps its own copy of the replacement metadata, predicts the
// victim way (or zero) for every accepted command beat and compares each
// result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module rrip_replacement_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        func,
	input  logic [10:0] set_index,
	input  logic [3:0]  way,
	input  logic [63:0] address,
	input  logic [63:0] pc,
	input  logic        hit,
	input  logic        done,
	input  logic [3:0]  victim_way,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          error_count,
	output int          pending_count
);

	// Mirror of the replacement metadata.
	logic [1:0]  rrpv_mem    [rrip_pkg::SETS][rrip_pkg::WAYS];
	logic [1:0]  dead_mem    [rrip_pkg::SETS][rrip_pkg::WAYS];
	logic [1:0]  reuse_mem   [rrip_pkg::SETS][rrip_pkg::SIG_N];
	logic [1:0]  conf_mem    [rrip_pkg::SETS];
	logic [63:0] prev_addr_mem   [rrip_pkg::SETS];
	logic [31:0] prev_stride_mem [rrip_pkg::SETS];
	logic [rrip_pkg::PSEL_BITS-1:0] duel_sel;
	logic [31:0] update_count;
	logic [15:0] bimodal_count;
	logic [31:0] decay_period;
	logic [15:0] bip_period;
	logic [20:0] stride_window;

	// Expected results in order of their command beats.
	logic [3:0] exp_fifo [16];
	int         exp_wr;
	int         exp_rd;

	assign pending_count = exp_wr - exp_rd;

	// Return every table and register to its reset contents.
	task automatic clear_mirror();
		for (int s = 0; s < rrip_pkg::SETS; s++) begin
			for (int w = 0; w < rrip_pkg::WAYS; w++) begin
				rrpv_mem[s][w] = 2'd3;
				dead_mem[s][w] = 2'd0;
			end
			for (int g = 0; g < rrip_pkg::SIG_N; g++)
				reuse_mem[s][g] = 2'd1;
			conf_mem[s]        = 2'd0;
			prev_addr_mem[s]   = '0;
			prev_stride_mem[s] = '0;
		end
		duel_sel      = rrip_pkg::PSEL_HALF;
		update_count  = '0;
		bimodal_count = '0;
		decay_period  = 32'd100000;
		bip_period    = 16'd32;
		stride_window = 21'd8192;
	endtask

	// Victim choice: first way at RRPV 3, then the highest lower RRPV with a
	// dead counter of at least 2, otherwise way 0.
	function automatic logic [3:0] choose_victim(int s);
		for (int w = 0; w < rrip_pkg::WAYS; w++)
			if (rrpv_mem[s][w] == 2'd3)
				return 4'(w);
		for (int r = 2; r >= 0; r--)
			for (int w = 0; w < rrip_pkg::WAYS; w++)
				if (rrpv_mem[s][w] == 2'(r) && dead_mem[s][w] >= 2'd2)
					return 4'(w);
		return 4'd0;
	endfunction

	// Queue one expected result.
	task automatic add_expected(logic [3:0] v);
		exp_fifo[exp_wr & 15] = v;
		exp_wr++;
	endtask

	// Train the metadata for one access and write the way's RRPV.
	task automatic train_access(int s, int w, logic [63:0] a, logic [63:0] p, logic h);
		logic [31:0]                   stride;
		logic [31:0]                   mag;
		logic [63:0]                   mix;
		logic [rrip_pkg::SIG_BITS-1:0] g;
		logic                          lead_st;
		logic                          lead_bi;
		logic                          static_ins;
		logic [1:0]                    ins;
		stride = (prev_addr_mem[s] != 0) ? (a[31:0] - prev_addr_mem[s][31:0]) : 32'd0;
		mag    = stride[31] ? (32'd0 - stride) : stride;
		if (stride != 0 && mag < {11'd0, stride_window}) begin
			if (stride == prev_stride_mem[s]) begin
				if (conf_mem[s] != 2'd3)
					conf_mem[s]++;
			end else if (conf_mem[s] != 2'd0) begin
				conf_mem[s]--;
			end
			prev_stride_mem[s] = stride;
		end else begin
			if (conf_mem[s] != 2'd0)
				conf_mem[s]--;
			prev_stride_mem[s] = '0;
		end
		prev_addr_mem[s] = a;

		mix = p ^ (p >> 9) ^ (p >> 15);
		g   = mix[rrip_pkg::SIG_BITS-1:0];
		if (h) begin
			if (reuse_mem[s][g] != 2'd3)
				reuse_mem[s][g]++;
			dead_mem[s][w] = 2'd0;
		end else if (dead_mem[s][w] != 2'd3) begin
			dead_mem[s][w]++;
		end

		lead_st = s < rrip_pkg::LEADER_SETS;
		lead_bi = s >= rrip_pkg::SETS - rrip_pkg::LEADER_SETS;
		if (lead_st && !h && duel_sel != rrip_pkg::PSEL_TOP)
			duel_sel++;
		if (lead_bi && h && duel_sel != 0)
			duel_sel--;

		// Periodic halving of every dead-block counter.
		update_count++;
		if (update_count >= decay_period) begin
			update_count = '0;
			for (int i = 0; i < rrip_pkg::SETS; i++)
				for (int j = 0; j < rrip_pkg::WAYS; j++)
					dead_mem[i][j] = dead_mem[i][j] >> 1;
		end

		if (h) begin
			rrpv_mem[s][w] = 2'd0;
		end else begin
			ins = 2'd3;
			if (conf_mem[s] < 2'd2) begin
				if (reuse_mem[s][g] >= 2'd2)
					ins = 2'd2;
				if (dead_mem[s][w] >= 2'd2)
					ins = 2'd3;
			end
			if (lead_st)
				static_ins = 1'b1;
			else if (lead_bi)
				static_ins = 1'b0;
			else
				static_ins = duel_sel < rrip_pkg::PSEL_HALF;
			if (!static_ins) begin
				bimodal_count++;
				if (bimodal_count >= bip_period) begin
					bimodal_count = '0;
					ins = 2'd2;
				end else begin
					ins = 2'd3;
				end
			end
			rrpv_mem[s][w] = ins;
		end
	endtask

	// Result beats are checked before new command beats are predicted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_mirror();
			exp_wr = 0;
			exp_rd = 0;
			error_count <= 0;
		end else begin
			if (done) begin
				if (exp_wr == exp_rd) begin
					$display("%0t: result beat with nothing expected, victim_way=%0d",
						$time, victim_way);
					error_count <= error_count + 1;
				end else if (exp_fifo[exp_rd & 15] !== victim_way) begin
					$display("%0t: victim_way mismatch, expected %0d, actual %0d",
						$time, exp_fifo[exp_rd & 15], victim_way);
					error_count <= error_count + 1;
					exp_rd++;
				end else begin
					exp_rd++;
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					rrip_pkg::REG_DECAY:  decay_period  = cfg_data;
					rrip_pkg::REG_BIP:    bip_period    = cfg_data[15:0];
					rrip_pkg::REG_STRIDE: stride_window = cfg_data[20:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				if (func == rrip_pkg::FUNC_VICTIM) begin
					add_expected(choose_victim(int'(set_index)));
				end else begin
					train_access(int'(set_index), int'(way), address, pc, hit);
					add_expected(4'd0);
				end
			end
		end
	end

endmodule

>>> bench/tb_rrip_ship_dip_cache_replacement_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rrip_ship_dip_cache_replacement_unit
// Drives directed and random victim and update commands into the replacement
// unit under several register settings, with random gaps between beats. A
// checker module beside the unit predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_rrip_ship_dip_cache_replacement_unit;

	localparam logic FUNC_UPDATE = ~rrip_pkg::FUNC_VICTIM;
	localparam int   CYCLE_LIMIT = 10000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        func = rrip_pkg::FUNC_VICTIM;
	logic [10:0] set_index = '0;
	logic [3:0]  way = '0;
	logic [63:0] address = '0;
	logic [63:0] pc = '0;
	logic        hit = 1'b0;
	logic        done;
	logic [3:0]  victim_way;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	int          error_count;
	int          pending_count;
	int          cycle_count = 0;
	int          idle_pct = 0;

	// Stream position per set and a small pool of program counters.
	logic [63:0] stream_pos [rrip_pkg::SETS];
	logic [63:0] pc_pool [8];

	always #6 clk = ~clk;

	rrip_ship_dip_cache_replacement_unit dut (.*);

	rrip_replacement_checker checker_i (.*);

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// One command beat, with an optional gap before it.
	task automatic send_command(logic f, logic [10:0] s, logic [3:0] w, logic [63:0] a,
		logic [63:0] p, logic h);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start     <= 1'b1;
		func      <= f;
		set_index <= s;
		way       <= w;
		address   <= a;
		pc        <= p;
		hit       <= h;
		do @(posedge clk); while (busy);
	endtask

	// Stop sending and wait until every result has come back.
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending_count != 0 || busy);
		repeat (4) @(posedge clk);
	endtask

	// One register beat; the caller drops valid after the last one.
	task automatic write_reg(logic [1:0] idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_regs(logic [31:0] decay, logic [31:0] bip, logic [31:0] window);
		drain();
		write_reg(rrip_pkg::REG_DECAY, decay);
		write_reg(rrip_pkg::REG_BIP, bip);
		write_reg(rrip_pkg::REG_STRIDE, window);
		cfg_valid <= 1'b0;
	endtask

	// Random beat: mostly well-formed strided streams on a few hot sets of each
	// dueling class, with repeating program counters, plus some pure noise.
	task automatic random_command();
		logic [10:0] s;
		logic [63:0] a;
		logic [63:0] p;
		int          r;
		r = $urandom_range(99);
		if (r < 25)
			s = 11'($urandom_range(3));
		else if (r < 50)
			s = 11'(rrip_pkg::SETS - 1 - $urandom_range(3));
		else if (r < 80)
			s = 11'(700 + $urandom_range(3));
		else
			s = 11'($urandom);
		r = $urandom_range(99);
		if (r < 70) begin
			case (s[1:0])
				2'd0: a = stream_pos[s] + 64'd64;
				2'd1: a = stream_pos[s] - 64'd128;
				2'd2: a = stream_pos[s] + 64'd4096;
				default: a = stream_pos[s] + 64'($urandom_range(1, 20000));
			endcase
		end else if (r < 85) begin
			a = stream_pos[s];
		end else begin
			a = {$urandom, $urandom};
		end
		stream_pos[s] = a;
		p = ($urandom_range(99) < 80) ? pc_pool[$urandom_range(7)] : {$urandom, $urandom};
		send_command(($urandom_range(99) < 45) ? rrip_pkg::FUNC_VICTIM : FUNC_UPDATE, s,
			4'($urandom), a, p, $urandom_range(99) < 40);
	endtask

	task automatic random_phase(int count);
		for (int i = 0; i < count; i++) begin
			if (i < count / 3)
				idle_pct = 32;
			else if (i < 2 * count / 3)
				idle_pct = 60;
			else
				idle_pct = 0;
			// Hold off once mid-phase until all results are in.
			if (i == count / 2) begin
				start <= 1'b0;
				do @(posedge clk); while (pending_count != 0);
			end
			random_command();
		end
	endtask

	initial begin
		for (int i = 0; i < rrip_pkg::SETS; i++)
			stream_pos[i] = {$urandom, $urandom} & 64'h0000_00FF_FFFF_FFC0;
		for (int i = 0; i < 8; i++)
			pc_pool[i] = {$urandom, $urandom};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: first access, streaming, signature reuse, leader sets,
		// extreme strides and fields, and a full set with no candidate.
		idle_pct = 20;
		send_command(rrip_pkg::FUNC_VICTIM, 11'd0, 4'd0, 64'd0, 64'd0, 1'b0);
		send_command(FUNC_UPDATE, 11'd0, 4'd5, 64'h1000, 64'd0, 1'b0);
		send_command(FUNC_UPDATE, 11'd0, 4'd5, 64'h1040, 64'd0, 1'b0);
		send_command(FUNC_UPDATE, 11'd0, 4'd6, 64'h1080, 64'd0, 1'b0);
		send_command(FUNC_UPDATE, 11'd0, 4'd7, 64'h10C0, 64'd0, 1'b0);
		send_command(FUNC_UPDATE, 11'd0, 4'd3, 64'h9000, '1, 1'b1);
		send_command(FUNC_UPDATE, 11'd0, 4'd3, 64'h9000, '1, 1'b1);
		send_command(FUNC_UPDATE, 11'd0, 4'd8, 64'h0, '1, 1'b0);
		send_command(rrip_pkg::FUNC_VICTIM, 11'd0, 4'd15, '1, '1, 1'b1);
		send_command(FUNC_UPDATE, 11'd2047, 4'd15, '1, '1, 1'b1);
		send_command(FUNC_UPDATE, 11'd2047, 4'd0, '1, '1, 1'b0);
		send_command(FUNC_UPDATE, 11'd1500, 4'd9, 64'h1_0000_0000, 64'd1, 1'b0);
		send_command(FUNC_UPDATE, 11'd1500, 4'd9, 64'h0_8000_0000, 64'd1, 1'b0);
		send_command(FUNC_UPDATE, 11'd63, 4'd1, 64'd5, 64'd2, 1'b0);
		send_command(FUNC_UPDATE, 11'd64, 4'd1, 64'd5, 64'd2, 1'b1);
		send_command(FUNC_UPDATE, 11'd1983, 4'd2, 64'd9, 64'd3, 1'b1);
		send_command(FUNC_UPDATE, 11'd1984, 4'd2, 64'd9, 64'd3, 1'b0);
		send_command(rrip_pkg::FUNC_VICTIM, 11'd1500, 4'd0, 64'd0, 64'd0, 1'b0);
		for (int w = 0; w < rrip_pkg::WAYS; w++)
			send_command(FUNC_UPDATE, 11'd10, 4'(w), 64'd0, 64'd7, 1'b1);
		send_command(rrip_pkg::FUNC_VICTIM, 11'd10, 4'd0, 64'd0, 64'd0, 1'b0);

		// Register settings of ones, zeros and the largest values, then ordinary ones.
		set_regs(32'd1, 32'd1, 32'd1);
		random_phase(20);
		set_regs(32'd0, 32'd0, 32'd0);
		random_phase(12);
		set_regs('1, 32'hFFFF, 32'h10_0000);
		random_phase(230);
		set_regs(32'd40, 32'd4, 32'd8192);
		random_phase(240);
		set_regs(32'd300, 32'd32, 32'd64);
		random_phase(240);

		drain();
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> files.f
src/rrip_pkg.sv
src/rrip_ram.sv
src/rrip_ship_dip_cache_replacement_unit.sv
bench/rrip_replacement_checker.sv
bench/tb_rrip_ship_dip_cache_replacement_unit.sv
